// File: hw/rtl/rrts_pkg.sv
// Shared types and constants for the round-robin transmit scheduler.
`timescale 1ns / 1ps
`default_nettype none
package rrts_pkg;

  localparam int OP_W   = 2;
  localparam int SLOT_W = 8;
  localparam int LEN_W  = 7;
  localparam int TIME_W = 32;
  localparam int CFG_W  = 16;
  localparam int STAT_W = 2;

  localparam logic [CFG_W-1:0] TIMEOUT_RESET = 16'd1000;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_POST    = 2'd2,
    OP_STEP    = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_NO_SLOT = 2'd1,
    ST_BUSY    = 2'd2,
    ST_BAD_ARG = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_SCAN   = 3'b001,
    PH_WAIT   = 3'b010,
    PH_FINISH = 3'b100
  } phase_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// File: hw/rtl/rrts_in_if.sv
// Request channel interface of the transmit scheduler.
`timescale 1ns / 1ps
`default_nettype none
interface rrts_in_if;
  import rrts_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [SLOT_W-1:0] socket_id;
  logic [LEN_W-1:0]  length;
  logic [TIME_W-1:0] now_ms;
  logic              rx_done;
  logic              tx_done;

  modport source (output valid, operation, socket_id, length, now_ms, rx_done, tx_done,
                  input ready);
  modport sink (input valid, operation, socket_id, length, now_ms, rx_done, tx_done,
                output ready);
endinterface
`default_nettype wire

// File: hw/rtl/rrts_out_if.sv
// Result channel interface of the transmit scheduler.
`timescale 1ns / 1ps
`default_nettype none
interface rrts_out_if;
  import rrts_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [SLOT_W-1:0] slot_out;
  logic [LEN_W-1:0]  tx_length;
  logic              start_tx;
  logic              resume_rx;

  modport source (output valid, status, slot_out, tx_length, start_tx, resume_rx,
                  input ready);
  modport sink (input valid, status, slot_out, tx_length, start_tx, resume_rx,
                output ready);
endinterface
`default_nettype wire

// File: hw/rtl/round_robin_tx_scheduler.sv
// Top level of the round-robin transmit scheduler for a shared half-duplex radio.
//
// Requests arrive on in_ch (valid/ready) and carry an operation: allocate a slot,
// release a slot, post a transmit length, or advance the scheduler by one step.
// Each request yields exactly one result on out_ch. The user must write the timeout
// register via cfg_we/cfg_wdata only while idle; the block does not enforce it.
//
// Each transaction has a capture step, which reads the pending-length RAM (one
// read port, registered read data), and an execute step, which updates the slot
// table and loads the result register, from which out_ch hands it over. No new
// request is taken until the execute step of the previous one has run.
// The request side is accepted while an earlier result still waits in the output
// register; if the receiver stalls, the next request is held in its execute cycle
// until the output register frees up, so nothing is lost or repeated.
//
// Synchronous reset frees all slots, clears all pending lengths through per-slot
// pending bits (no RAM clearing pass is needed), puts the scan at the first slot
// in the scan phase, and loads a timeout of 1000 ms.
`timescale 1ns / 1ps
`default_nettype none
module round_robin_tx_scheduler #(
  parameter int SLOTS   = 16,
  parameter int MAX_LEN = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [rrts_pkg::CFG_W-1:0] cfg_wdata,
  rrts_in_if.sink                    in_ch,
  rrts_out_if.source                 out_ch
);
  import rrts_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  // The controller only sequences; all table state sits in the datapath.
  rrts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (dp_status),
    .cmd      (cmd)
  );

  rrts_datapath #(
    .SLOTS   (SLOTS),
    .MAX_LEN (MAX_LEN)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (dp_status),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .operation     (in_ch.operation),
    .socket_id     (in_ch.socket_id),
    .length        (in_ch.length),
    .now_ms        (in_ch.now_ms),
    .rx_done       (in_ch.rx_done),
    .tx_done       (in_ch.tx_done),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_status    (out_ch.status),
    .out_slot      (out_ch.slot_out),
    .out_tx_length (out_ch.tx_length),
    .out_start_tx  (out_ch.start_tx),
    .out_resume_rx (out_ch.resume_rx)
  );

  // One request in flight: right after an accepted request, no new one is taken.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request accepted while another was in flight");

  // A result is only produced when the output register can take it.
  a_exec_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> dp_status.out_free)
    else $error("result overwrote a pending output");

  // Every accepted request leads to a result load in the following cycle
  // unless the receiver is holding the previous result.
  a_exec_follows: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> (cmd.exec || (out_ch.valid && !out_ch.ready)))
    else $error("accepted request was not executed");

  // A step never both starts a transmit and returns the radio to receive.
  a_tx_rx_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !(out_ch.start_tx && out_ch.resume_rx))
    else $error("start_tx and resume_rx in the same result");

endmodule
`default_nettype wire

// File: hw/rtl/rrts_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module rrts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/rrts_ctrl.sv
// Controller state machine: sequences capture and execute of each transaction.
`timescale 1ns / 1ps
`default_nettype none
module rrts_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  rrts_pkg::dp_status_t   status,
  output rrts_pkg::ctrl_cmd_t    cmd
);
  import rrts_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } ctrl_state_t;

  ctrl_state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        // Hold the captured request until the result register can take it.
        if (status.out_free) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/rrts_datapath.sv
// Datapath: slot table, pending-length RAM, scheduler phase and result register.
`timescale 1ns / 1ps
`default_nettype none
module rrts_datapath #(
  parameter int SLOTS   = 16,
  parameter int MAX_LEN = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rrts_pkg::ctrl_cmd_t           cmd,
  output rrts_pkg::dp_status_t          status,
  input  logic                          cfg_we,
  input  logic [rrts_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic [rrts_pkg::OP_W-1:0]     operation,
  input  logic [rrts_pkg::SLOT_W-1:0]   socket_id,
  input  logic [rrts_pkg::LEN_W-1:0]    length,
  input  logic [rrts_pkg::TIME_W-1:0]   now_ms,
  input  logic                          rx_done,
  input  logic                          tx_done,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [rrts_pkg::STAT_W-1:0]   out_status,
  output logic [rrts_pkg::SLOT_W-1:0]   out_slot,
  output logic [rrts_pkg::LEN_W-1:0]    out_tx_length,
  output logic                          out_start_tx,
  output logic                          out_resume_rx
);
  import rrts_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(SLOTS - 1);
  localparam logic [SLOT_W:0]   SLOTS_X   = (SLOT_W + 1)'(SLOTS);
  localparam logic [LEN_W:0]    MAX_LEN_X = (LEN_W + 1)'(MAX_LEN);

  // Captured request.
  op_t               op_q;
  logic [SLOT_W-1:0] id_q;
  logic [LEN_W-1:0]  len_q;
  logic [TIME_W-1:0] now_q;
  logic              rxd_q;
  logic              txd_q;

  // Scheduler state. A slot's pending bit is set exactly when its length is nonzero;
  // the length value itself lives in the RAM.
  logic [SLOTS-1:0]  used, used_next;
  logic [SLOTS-1:0]  pend, pend_next;
  logic [IDX_W-1:0]  scan_idx, scan_next;
  phase_t            phase, phase_next;
  logic [TIME_W-1:0] attempt_start, attempt_next;
  logic [CFG_W-1:0]  timeout;

  logic [SLOT_W-1:0] id_m1_in;
  logic [IDX_W-1:0]  rd_addr;
  logic [LEN_W-1:0]  ram_rdata;
  logic              ram_we;

  logic [SLOT_W-1:0] id_m1;
  logic [IDX_W-1:0]  id_idx;
  logic              id_ok;
  logic              len_ok;
  logic              free_found;
  logic [IDX_W-1:0]  free_idx;
  logic [IDX_W-1:0]  scan_adv;
  logic [TIME_W-1:0] elapsed;
  logic              timed_out;

  status_t           r_status;
  logic [SLOT_W-1:0] r_slot;
  logic [LEN_W-1:0]  r_len;
  logic              r_start;
  logic              r_resume;

  // Read address is chosen from the incoming request so the data is ready next cycle.
  assign id_m1_in = socket_id - SLOT_W'(1);
  assign rd_addr  = (op_t'(operation) == OP_STEP) ? scan_idx : id_m1_in[IDX_W-1:0];

  rrts_ram #(
    .WIDTH (LEN_W),
    .DEPTH (SLOTS)
  ) u_pend_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (id_idx),
    .wdata (len_q),
    .re    (cmd.capture),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= op_t'(operation);
      id_q  <= socket_id;
      len_q <= length;
      now_q <= now_ms;
      rxd_q <= rx_done;
      txd_q <= tx_done;
    end
  end

  assign id_m1     = id_q - SLOT_W'(1);
  assign id_idx    = id_m1[IDX_W-1:0];
  assign id_ok     = (id_q != '0) && ({1'b0, id_q} <= SLOTS_X);
  assign len_ok    = {1'b0, len_q} <= MAX_LEN_X;
  assign scan_adv  = (scan_idx == LAST_IDX) ? '0 : scan_idx + IDX_W'(1);
  assign elapsed   = now_q - attempt_start;
  assign timed_out = elapsed > TIME_W'(timeout);

  // Lowest free slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    used_next    = used;
    pend_next    = pend;
    scan_next    = scan_idx;
    phase_next   = phase;
    attempt_next = attempt_start;
    ram_we       = 1'b0;
    r_status     = ST_OK;
    r_slot       = '0;
    r_len        = '0;
    r_start      = 1'b0;
    r_resume     = 1'b0;
    case (op_q)
      OP_ALLOC: begin
        if (free_found) begin
          used_next[free_idx] = 1'b1;
          pend_next[free_idx] = 1'b0;
          r_slot = SLOT_W'(free_idx) + SLOT_W'(1);
        end else begin
          r_status = ST_NO_SLOT;
        end
      end
      OP_RELEASE: begin
        if (!id_ok) begin
          r_status = ST_BAD_ARG;
        end else if (used[id_idx]) begin
          used_next[id_idx] = 1'b0;
          pend_next[id_idx] = 1'b0;
        end
      end
      OP_POST: begin
        if (!id_ok || !len_ok) begin
          r_status = ST_BAD_ARG;
        end else if (pend[id_idx]) begin
          r_status = ST_BUSY;
        end else if (len_q != '0) begin
          pend_next[id_idx] = 1'b1;
          ram_we = cmd.exec;
        end
      end
      OP_STEP: begin
        case (phase)
          PH_WAIT: begin
            if (txd_q) begin
              phase_next = PH_FINISH;
            end else if (timed_out) begin
              // Back to scan at the same slot, so the transmit is retried.
              phase_next = PH_SCAN;
            end
          end
          PH_FINISH: begin
            pend_next[scan_idx] = 1'b0;
            r_resume   = 1'b1;
            phase_next = PH_SCAN;
            scan_next  = scan_adv;
          end
          default: begin
            phase_next = PH_SCAN;
            if (pend[scan_idx] && !rxd_q) begin
              attempt_next = now_q;
              r_start      = 1'b1;
              r_slot       = SLOT_W'(scan_idx) + SLOT_W'(1);
              r_len        = ram_rdata;
              phase_next   = PH_WAIT;
            end else begin
              scan_next = scan_adv;
            end
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used          <= '0;
      pend          <= '0;
      scan_idx      <= '0;
      phase         <= PH_SCAN;
      attempt_start <= '0;
    end else if (cmd.exec) begin
      used          <= used_next;
      pend          <= pend_next;
      scan_idx      <= scan_next;
      phase         <= phase_next;
      attempt_start <= attempt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout <= cfg_wdata;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_status    <= r_status;
      out_slot      <= r_slot;
      out_tx_length <= r_len;
      out_start_tx  <= r_start;
      out_resume_rx <= r_resume;
    end
  end

  assign status.out_free = !out_valid || out_ready;

endmodule
`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the round-robin transmit scheduler.
`timescale 1ns / 1ps
module testbench;
  import rrts_pkg::*;

  localparam int SLOTS = 16;
  localparam int MAX_LEN = 64;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned ITEMS_PER_PHASE = 258;
  localparam int NUM_PHASES = 6;

  // One result transaction as it appears on the result channel.
  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  tx_len;
    logic              start;
    logic              resume;
  } tx_result_t;

  // Tracks the slot table and the scheduler phase, and holds the results that
  // accepted request transactions must still produce, oldest first.
  class schedule_tracker;
    bit                used[SLOTS];
    logic [LEN_W-1:0]  pending[SLOTS];
    int unsigned       scan_pos;
    phase_t            phase;
    logic [TIME_W-1:0] attempt_start;
    logic [CFG_W-1:0]  timeout_ms;
    tx_result_t        awaited_results[$];
    int unsigned       mismatches;

    function new();
      foreach (used[i]) begin
        used[i] = 1'b0;
        pending[i] = '0;
      end
      scan_pos = 0;
      phase = PH_SCAN;
      attempt_start = '0;
      timeout_ms = TIMEOUT_RESET;
      mismatches = 0;
    endfunction

    function void set_timeout(logic [CFG_W-1:0] value);
      timeout_ms = value;
    endfunction

    function void next_slot();
      scan_pos = (scan_pos == SLOTS - 1) ? 0 : scan_pos + 1;
    endfunction

    function int unsigned outstanding();
      return awaited_results.size();
    endfunction

    // Applies one accepted request to the tracked state and queues its result.
    function void note_request(op_t op, logic [SLOT_W-1:0] id, logic [LEN_W-1:0] len,
                               logic [TIME_W-1:0] now, bit rxd, bit txd);
      tx_result_t r;
      bit found;
      int idx;
      r = '0;
      r.status = ST_OK;
      found = 1'b0;
      idx = scan_pos;
      case (op)
        OP_ALLOC: begin
          r.status = ST_NO_SLOT;
          for (int i = 0; i < SLOTS; i++) begin
            if (!found && !used[i]) begin
              found = 1'b1;
              used[i] = 1'b1;
              pending[i] = '0;
              r.slot = i + 1;
              r.status = ST_OK;
            end
          end
        end
        OP_RELEASE: begin
          if (id < 1 || id > SLOTS) begin
            r.status = ST_BAD_ARG;
          end else if (used[id - 1]) begin
            used[id - 1] = 1'b0;
            pending[id - 1] = '0;
          end
        end
        OP_POST: begin
          if (id < 1 || id > SLOTS || len > MAX_LEN) begin
            r.status = ST_BAD_ARG;
          end else if (pending[id - 1] != 0) begin
            r.status = ST_BUSY;
          end else begin
            pending[id - 1] = len;
          end
        end
        default: begin
          case (phase)
            PH_WAIT: begin
              if (txd) begin
                phase = PH_FINISH;
              end else if (now - attempt_start > {16'd0, timeout_ms}) begin
                phase = PH_SCAN;
              end
            end
            PH_FINISH: begin
              pending[idx] = '0;
              r.resume = 1'b1;
              phase = PH_SCAN;
              next_slot();
            end
            default: begin
              phase = PH_SCAN;
              if (pending[idx] != 0 && !rxd) begin
                attempt_start = now;
                r.start = 1'b1;
                r.slot = idx + 1;
                r.tx_len = pending[idx];
                phase = PH_WAIT;
              end else begin
                next_slot();
              end
            end
          endcase
        end
      endcase
      awaited_results.push_back(r);
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(tx_result_t got);
      tx_result_t want;
      if (awaited_results.size() == 0) begin
        report("result transaction with nothing outstanding");
      end else begin
        want = awaited_results.pop_front();
        if (got.status !== want.status)
          report($sformatf("status %0d, wanted %0d", got.status, want.status));
        if (got.slot !== want.slot)
          report($sformatf("slot_out %0d, wanted %0d", got.slot, want.slot));
        if (got.tx_len !== want.tx_len)
          report($sformatf("tx_length %0d, wanted %0d", got.tx_len, want.tx_len));
        if (got.start !== want.start)
          report($sformatf("start_tx %0b, wanted %0b", got.start, want.start));
        if (got.resume !== want.resume)
          report($sformatf("resume_rx %0b, wanted %0b", got.resume, want.resume));
      end
    endtask
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  rrts_in_if  req_ch ();
  rrts_out_if rsp_ch ();

  round_robin_tx_scheduler dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (req_ch),
    .out_ch    (rsp_ch)
  );

  schedule_tracker   tracker;
  int unsigned       cycle_count;
  bit                steady;       // When set, neither side inserts idle cycles.
  logic [TIME_W-1:0] clock_ms;     // Millisecond time handed to step transactions.
  logic [CFG_W-1:0]  tmo_now;      // Timeout currently programmed into the block.

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The run is ended here if the block stops making progress.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Mostly no gap or a short one; now and then a long one. While steady is set
  // both channels run at full rate.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // The monitors sample at the rising edge, where both channels settle their
  // handshakes. A result can only be handed over at a later edge than its request,
  // so the two monitors never depend on each other within one edge.
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready)
      tracker.note_request(op_t'(req_ch.operation), req_ch.socket_id, req_ch.length,
                           req_ch.now_ms, req_ch.rx_done, req_ch.tx_done);
  end

  always @(posedge clk) begin
    tx_result_t got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.status = status_t'(rsp_ch.status);
      got.slot = rsp_ch.slot_out;
      got.tx_len = rsp_ch.tx_length;
      got.start = rsp_ch.start_tx;
      got.resume = rsp_ch.resume_rx;
      tracker.check_result(got);
    end
  end

  // The receiver alternates runs of ready with stalls of random length.
  initial begin
    int unsigned run_len;
    int unsigned stall_len;
    rsp_ch.ready = 1'b0;
    forever begin
      run_len = $urandom_range(1, 20);
      repeat (run_len) begin
        @(negedge clk);
        rsp_ch.ready <= 1'b1;
      end
      stall_len = pick_gap();
      repeat (stall_len) begin
        @(negedge clk);
        rsp_ch.ready <= 1'b0;
      end
    end
  end

  // Offers one request transaction, after a random gap, and holds it until the
  // block takes it. Valid stays high afterwards so that the next call can
  // follow back to back; go_quiet lowers it when nothing follows.
  task automatic send_request(op_t op, logic [SLOT_W-1:0] id, logic [LEN_W-1:0] len,
                              logic [TIME_W-1:0] now, bit rxd, bit txd);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid <= 1'b1;
    req_ch.operation <= op;
    req_ch.socket_id <= id;
    req_ch.length <= len;
    req_ch.now_ms <= now;
    req_ch.rx_done <= rxd;
    req_ch.tx_done <= txd;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic go_quiet();
    @(negedge clk);
    req_ch.valid <= 1'b0;
  endtask

  // Waits until every result the tracker has queued has come out.
  task automatic drain();
    while (tracker.outstanding() != 0) @(posedge clk);
  endtask

  // The timeout register is written only while no transaction is in flight.
  task automatic write_timeout(logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    tracker.set_timeout(value);
    tmo_now = value;
  endtask

  // Mostly ids of real slots, sometimes zero or past the end of the table.
  function automatic logic [SLOT_W-1:0] pick_id();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 88) return $urandom_range(1, SLOTS);
    if (r < 92) return 0;
    return $urandom_range(SLOTS + 1, 255);
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) return 0;
    if (r < 88) return $urandom_range(1, MAX_LEN);
    return $urandom_range(MAX_LEN + 1, 127);
  endfunction

  // Advances the millisecond time for a step. Most steps move forward by up to
  // half the timeout plus 2 ms, some land right around the timeout boundary, and
  // a few jump to an arbitrary time.
  task automatic random_step();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70)
      clock_ms = clock_ms + $urandom_range(0, tmo_now / 2 + 2);
    else if (r < 90)
      clock_ms = clock_ms + tmo_now + $urandom_range(0, 2) - 1;
    else
      clock_ms = $urandom;
    send_request(OP_STEP, $urandom_range(0, 255), $urandom_range(0, 127), clock_ms,
                 $urandom_range(0, 4) == 0, $urandom_range(0, 3) == 0);
  endtask

  // One random request transaction. The allocate share is varied between
  // phases so that the table both fills up completely and stays sparse.
  task automatic random_item(int unsigned alloc_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < alloc_pct)
      send_request(OP_ALLOC, $urandom_range(0, 255), $urandom_range(0, 127), $urandom,
                   $urandom_range(0, 1), $urandom_range(0, 1));
    else if (r < alloc_pct + 10)
      send_request(OP_RELEASE, pick_id(), $urandom_range(0, 127), $urandom,
                   $urandom_range(0, 1), $urandom_range(0, 1));
    else if (r < alloc_pct + 38)
      send_request(OP_POST, pick_id(), pick_len(), $urandom,
                   $urandom_range(0, 1), $urandom_range(0, 1));
    else
      random_step();
  endtask

  initial begin
    logic [TIME_W-1:0] t0;
    logic [CFG_W-1:0]  phase_tmo;
    int unsigned       alloc_pct;

    tracker = new();
    cycle_count = 0;
    steady = 1'b0;
    tmo_now = TIMEOUT_RESET;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.operation = OP_ALLOC;
    req_ch.socket_id = '0;
    req_ch.length = '0;
    req_ch.now_ms = '0;
    req_ch.rx_done = 1'b0;
    req_ch.tx_done = 1'b0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Directed part, run with the reset timeout of 1000 ms. The attempt starts
    // just before the time counter wraps, so the timeout check crosses zero.
    t0 = 32'hFFFF_FC00;
    send_request(OP_ALLOC, 8'd0, 7'd0, 32'd0, 1'b0, 1'b0);
    send_request(OP_POST, 8'd1, 7'd64, 32'd0, 1'b0, 1'b0);
    // A second post to a slot that already has a length pending is busy.
    send_request(OP_POST, 8'd1, 7'd5, 32'd0, 1'b0, 1'b0);
    send_request(OP_STEP, 8'd0, 7'd0, t0, 1'b0, 1'b0);
    // Exactly the timeout has elapsed: still waiting. One more ms times out.
    send_request(OP_STEP, 8'd0, 7'd0, t0 + 32'd1000, 1'b0, 1'b0);
    send_request(OP_STEP, 8'd0, 7'd0, t0 + 32'd1001, 1'b0, 1'b0);
    // After the timeout the same slot is retried.
    send_request(OP_STEP, 8'd0, 7'd0, t0 + 32'd1500, 1'b0, 1'b0);
    // Releasing the slot while its transmit is in flight.
    send_request(OP_RELEASE, 8'd1, 7'd0, 32'd0, 1'b0, 1'b0);
    send_request(OP_STEP, 8'd0, 7'd0, t0 + 32'd1600, 1'b0, 1'b1);
    send_request(OP_STEP, 8'd0, 7'd0, t0 + 32'd1700, 1'b0, 1'b0);
    send_request(OP_ALLOC, 8'd255, 7'd127, 32'hFFFF_FFFF, 1'b1, 1'b1);
    // A post to a slot that was never allocated is still taken.
    send_request(OP_POST, 8'd2, 7'd3, 32'd0, 1'b0, 1'b0);
    // A receive that has completed holds off the transmit for this scan.
    send_request(OP_STEP, 8'd0, 7'd0, t0 + 32'd1800, 1'b1, 1'b0);
    send_request(OP_POST, 8'd3, 7'd0, 32'd0, 1'b0, 1'b0);
    send_request(OP_POST, 8'd0, 7'd10, 32'd0, 1'b0, 1'b0);
    send_request(OP_POST, 8'd17, 7'd10, 32'd0, 1'b0, 1'b0);
    send_request(OP_POST, 8'd255, 7'd127, 32'd0, 1'b0, 1'b0);
    send_request(OP_POST, 8'd4, 7'd65, 32'd0, 1'b0, 1'b0);
    send_request(OP_RELEASE, 8'd0, 7'd0, 32'd0, 1'b0, 1'b0);
    send_request(OP_RELEASE, 8'd255, 7'd0, 32'd0, 1'b0, 1'b0);
    // Releasing a slot that is already free is harmless.
    send_request(OP_RELEASE, 8'd9, 7'd0, 32'd0, 1'b0, 1'b0);
    send_request(OP_RELEASE, 8'd1, 7'd0, 32'd0, 1'b0, 1'b0);
    clock_ms = t0 + 32'd1800;

    // Random part in phases, each with its own timeout setting. The phases
    // cover the zero and full-scale timeouts, the reset value and random ones.
    for (int p = 0; p < NUM_PHASES; p++) begin
      go_quiet();
      drain();
      repeat (4) @(negedge clk);
      case (p)
        0: phase_tmo = 16'd0;
        1: phase_tmo = 16'hFFFF;
        2: phase_tmo = $urandom_range(1, 200);
        3: phase_tmo = TIMEOUT_RESET;
        4: phase_tmo = $urandom_range(0, 65535);
        default: phase_tmo = 16'd25;
      endcase
      write_timeout(phase_tmo);
      alloc_pct = (p % 2 == 0) ? 30 : 8;
      steady = (p == 3);
      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Midway through one phase the sender holds off until the block has
        // returned every result it owes.
        if (p == 2 && n == ITEMS_PER_PHASE / 2) begin
          go_quiet();
          drain();
        end
        random_item(alloc_pct);
      end
    end
    steady = 1'b0;

    go_quiet();
    drain();
    repeat (10) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
